// ===== design/cpi_pkg.sv =====
package cpi_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int MAX_FRAME_DEF = 4096;
  localparam int GUARD         = 8;

  localparam int CW        = 22;  // centre coordinate
  localparam int RAD_W     = 17;  // radius
  localparam int DLT_W     = 23;  // centre delta
  localparam int FRM_W     = 13;  // frame size register
  localparam int PIX_W     = 12;  // pixel coordinate
  localparam int CFG_IDX_W = 2;
  localparam int SQR_W     = 34;  // r^2
  localparam int KMAG_W    = 37;  // |K|
  localparam int D8_W      = 26;  // distance, guard scaled
  localparam int H8_W      = 25;  // half chord, guard scaled
  localparam int QW        = 28;  // quotient magnitude
  localparam int PROD_W    = 51;  // offset numerator before guard shift
  localparam int OFS_W     = 29;  // signed offset
  localparam int POS_W     = 32;  // signed crossing coordinate

  localparam logic [FRM_W-1:0] FRAME_W_RST = 13'd1024;
  localparam logic [FRM_W-1:0] FRAME_H_RST = 13'd768;

  typedef enum logic [1:0] {
    ST_APART  = 2'd0,
    ST_INSIDE = 2'd1,
    ST_OFF    = 2'd2,
    ST_VALID  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_W = 2'd0,
    CFG_FRAME_H = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    status_t          status;
    logic [PIX_W-1:0] pax;
    logic [PIX_W-1:0] pay;
    logic [PIX_W-1:0] pbx;
    logic [PIX_W-1:0] pby;
  } res_t;

  typedef struct packed {
    logic              v;
    logic              far;
    logic              cont;
    logic              kneg;
    logic [KMAG_W-1:0] kmag;
    logic [RAD_W-1:0]  r1;
    logic [SQR_W-1:0]  sq_r1;
    logic [CW-1:0]     x1;
    logic [CW-1:0]     y1;
    logic [DLT_W-1:0]  dx;
    logic [DLT_W-1:0]  dy;
  } sb1_t;

  typedef struct packed {
    logic             v;
    logic             far;
    logic             cont;
    logic             kneg;
    logic [RAD_W-1:0] r1;
    logic [SQR_W-1:0] sq_r1;
    logic [CW-1:0]    x1;
    logic [CW-1:0]    y1;
    logic [DLT_W-1:0] dx;
    logic [DLT_W-1:0] dy;
    logic [D8_W-1:0]  d8;
  } sb2_t;

  typedef struct packed {
    logic             v;
    logic             far;
    logic             cont;
    logic             aneg;
    logic [QW-1:0]    amag;
    logic [D8_W-1:0]  d8;
    logic [CW-1:0]    x1;
    logic [CW-1:0]    y1;
    logic [DLT_W-1:0] dx;
    logic [DLT_W-1:0] dy;
  } sb3_t;

  typedef struct packed {
    logic          v;
    logic          far;
    logic          cont;
    logic          smx;
    logic          smy;
    logic          shx;
    logic          shy;
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
  } sb4_t;

endpackage

// ===== design/cpi_in_if.sv =====
interface cpi_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [cpi_pkg::CW-1:0]  first_x;
  logic signed [cpi_pkg::CW-1:0]  first_y;
  logic [cpi_pkg::RAD_W-1:0]      first_r;
  logic signed [cpi_pkg::CW-1:0]  second_x;
  logic signed [cpi_pkg::CW-1:0]  second_y;
  logic [cpi_pkg::RAD_W-1:0]      second_r;

  modport source (output valid, first_x, first_y, first_r, second_x, second_y, second_r,
                  input ready);
  modport sink (input valid, first_x, first_y, first_r, second_x, second_y, second_r,
                output ready);
endinterface

// ===== design/cpi_out_if.sv =====
interface cpi_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [cpi_pkg::PIX_W-1:0] point_a_x;
  logic [cpi_pkg::PIX_W-1:0] point_a_y;
  logic [cpi_pkg::PIX_W-1:0] point_b_x;
  logic [cpi_pkg::PIX_W-1:0] point_b_y;

  modport source (output valid, status, point_a_x, point_a_y, point_b_x, point_b_y,
                  input ready);
  modport sink (input valid, status, point_a_x, point_a_y, point_b_x, point_b_y,
                output ready);
endinterface

// ===== design/cpi_cfg_if.sv =====
interface cpi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cpi_pkg::CFG_IDX_W-1:0] index;
  logic [cpi_pkg::FRM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/cpi_delay.sv =====
module cpi_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) sh_r[i] <= '0;
    end else if (en) begin
      sh_r[0] <= din;
      for (int i = 1; i < N; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  assign dout = sh_r[N-1];

endmodule

// ===== design/cpi_isqrt.sv =====
module cpi_isqrt #(
  parameter int RW = 26
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] n,
  output logic [RW-1:0]   root
);

  logic [2*RW-1:0] rem_r [RW-1];
  logic [RW-1:0]   rt_r  [RW];

  // one result bit per stage, MSB first
  for (genvar j = 0; j < RW; j++) begin : g_st
    localparam int B = RW - 1 - j;
    logic [2*RW-1:0] rem_in;
    logic [2*RW-1:0] trial;
    logic [RW-1:0]   rt_in;
    logic            ge;

    if (j == 0) begin : g_first
      assign rem_in = n;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign rt_in  = rt_r[j-1];
    end

    assign trial = ({{RW{1'b0}}, rt_in} << (B + 1)) |
                   ({{(2*RW-1){1'b0}}, 1'b1} << (2 * B));
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[j] <= ge ? (rt_in | (RW'(1) << B)) : rt_in;
      end
    end

    if (j < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root = rt_r[RW-1];

endmodule

// ===== design/cpi_div.sv =====
module cpi_div #(
  parameter int NW = 53,
  parameter int DW = 27,
  parameter int QW = 28
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q
);

  // restoring divide, quotient known to fit in QW bits
  logic [NW+DW-1:0] n_ext;
  logic [DW-1:0]    rem_r [QW-1];
  logic [QW-1:0]    lo_r  [QW-1];
  logic [DW-1:0]    d_r   [QW-1];
  logic [QW-1:0]    q_r   [QW];

  assign n_ext = {{DW{1'b0}}, n};

  for (genvar j = 0; j < QW; j++) begin : g_st
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = n_ext[QW +: DW];
      assign lo_in  = n[QW-1:0];
      assign d_in   = d;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign lo_in  = lo_r[j-1];
      assign d_in   = d_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign t    = {rem_in, lo_in[QW-1]};
    assign diff = t - {1'b0, d_in};
    assign ge   = t >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j] <= {q_in[QW-2:0], ge};
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? diff[DW-1:0] : t[DW-1:0];
          lo_r[j]  <= {lo_in[QW-2:0], 1'b0};
          d_r[j]   <= d_in;
        end
      end
    end
  end

  assign q = q_r[QW-1];

endmodule

// ===== design/cpi_obuf.sv =====
module cpi_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tail_v,
  input  cpi_pkg::res_t     tail_d,
  output logic              pipe_en,
  cpi_out_if.source         out_ch
);
  import cpi_pkg::*;

  logic out_v_r;
  logic skid_v_r;
  res_t out_d_r;
  res_t skid_d_r;
  logic pop;

  assign pop     = out_v_r && out_ch.ready;
  assign pipe_en = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (tail_v) begin
      if (!out_v_r || pop) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) out_d_r <= skid_d_r;
    end else if (tail_v) begin
      if (!out_v_r || pop) out_d_r <= tail_d;
      else skid_d_r <= tail_d;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.status    = out_d_r.status;
  assign out_ch.point_a_x = out_d_r.pax;
  assign out_ch.point_a_y = out_d_r.pay;
  assign out_ch.point_b_x = out_d_r.pbx;
  assign out_ch.point_b_y = out_d_r.pby;

  a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid word without output word");
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !pop |=> skid_v_r && $stable(skid_d_r)) else $error("skid word lost");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !skid_v_r && !tail_v |=> !out_v_r) else $error("word repeated");

endmodule

// ===== design/circle_pair_intersection.sv =====
// Circle pair intersection, fully pipelined.
// Throughput: one pair per cycle while the output buffer does not stall the pipeline;
// set by the bit-per-stage sqrt and divider pipelines.
// A two-word output buffer decouples in_ch.ready from out_ch.ready.
// Reset (rst_n low, synchronous) empties the pipeline and sets frame 1024 x 768.
module circle_pair_intersection #(
  parameter int FRAC_BITS = cpi_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAME = cpi_pkg::MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cpi_in_if.sink     in_ch,
  cpi_out_if.source  out_ch,
  cpi_cfg_if.sink    cfg_ch
);
  import cpi_pkg::*;

  localparam int SH = FRAC_BITS + GUARD;

  logic en;

  // frame registers
  logic [FRM_W-1:0] fw_r, fh_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_W_RST;
      fh_r <= FRAME_H_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_FRAME_W) fw_r <= cfg_ch.data;
      else if (cfg_ch.index == CFG_FRAME_H) fh_r <= cfg_ch.data;
    end
  end

  assign in_ch.ready = en;

  // stage 0: input capture
  logic             v0_r;
  logic [CW-1:0]    fx0_r, fy0_r, sx0_r, sy0_r;
  logic [RAD_W-1:0] fr0_r, sr0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx0_r <= in_ch.first_x;
      fy0_r <= in_ch.first_y;
      fr0_r <= in_ch.first_r;
      sx0_r <= in_ch.second_x;
      sy0_r <= in_ch.second_y;
      sr0_r <= in_ch.second_r;
    end
  end

  // stage 1: deltas
  logic             v1_r;
  logic [DLT_W-1:0] dx1_r, dy1_r;
  logic [RAD_W:0]   sum1_r, dif1_r;
  logic [RAD_W-1:0] r1_1_r, r2_1_r;
  logic [CW-1:0]    x1_1_r, y1_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r  <= {sx0_r[CW-1], sx0_r} - {fx0_r[CW-1], fx0_r};
      dy1_r  <= {sy0_r[CW-1], sy0_r} - {fy0_r[CW-1], fy0_r};
      sum1_r <= {1'b0, fr0_r} + {1'b0, sr0_r};
      dif1_r <= {1'b0, fr0_r} - {1'b0, sr0_r};
      r1_1_r <= fr0_r;
      r2_1_r <= sr0_r;
      x1_1_r <= fx0_r;
      y1_1_r <= fy0_r;
    end
  end

  // stage 2: squares
  logic             v2_r;
  logic [45:0]      sqdx2_r, sqdy2_r;
  logic [35:0]      sqs2_r, sqd2_r;
  logic [SQR_W-1:0] sqr1_2_r, sqr2_2_r;
  logic [DLT_W-1:0] dx2_r, dy2_r;
  logic [RAD_W-1:0] r1_2_r;
  logic [CW-1:0]    x1_2_r, y1_2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqdx2_r  <= $signed(dx1_r) * $signed(dx1_r);
      sqdy2_r  <= $signed(dy1_r) * $signed(dy1_r);
      sqs2_r   <= sum1_r * sum1_r;
      sqd2_r   <= $signed(dif1_r) * $signed(dif1_r);
      sqr1_2_r <= r1_1_r * r1_1_r;
      sqr2_2_r <= r2_1_r * r2_1_r;
      dx2_r    <= dx1_r;
      dy2_r    <= dy1_r;
      r1_2_r   <= r1_1_r;
      x1_2_r   <= x1_1_r;
      y1_2_r   <= y1_1_r;
    end
  end

  // stage 3: D2 and r1^2 - r2^2
  logic             v3_r;
  logic [46:0]      d2_3_r;
  logic [SQR_W:0]   kp3_r;
  logic [35:0]      sqs3_r, sqd3_r;
  logic [SQR_W-1:0] sqr1_3_r;
  logic [DLT_W-1:0] dx3_r, dy3_r;
  logic [RAD_W-1:0] r1_3_r;
  logic [CW-1:0]    x1_3_r, y1_3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_3_r   <= {1'b0, sqdx2_r} + {1'b0, sqdy2_r};
      kp3_r    <= {1'b0, sqr1_2_r} - {1'b0, sqr2_2_r};
      sqs3_r   <= sqs2_r;
      sqd3_r   <= sqd2_r;
      sqr1_3_r <= sqr1_2_r;
      dx3_r    <= dx2_r;
      dy3_r    <= dy2_r;
      r1_3_r   <= r1_2_r;
      x1_3_r   <= x1_2_r;
      y1_3_r   <= y1_2_r;
    end
  end

  // stage 4: classify, K, sqrt radicand
  logic [47:0] ksum, kabs;
  sb1_t        sb1_nxt, sb1_r;
  logic [51:0] rad4_r;

  always_comb begin
    ksum = {{(47 - SQR_W){kp3_r[SQR_W]}}, kp3_r} + {1'b0, d2_3_r};
    kabs = ksum[47] ? -ksum : ksum;
    sb1_nxt.v     = v3_r;
    sb1_nxt.far   = d2_3_r >= {11'b0, sqs3_r};
    sb1_nxt.cont  = d2_3_r <= {11'b0, sqd3_r};
    sb1_nxt.kneg  = ksum[47];
    sb1_nxt.kmag  = kabs[KMAG_W-1:0];
    sb1_nxt.r1    = r1_3_r;
    sb1_nxt.sq_r1 = sqr1_3_r;
    sb1_nxt.x1    = x1_3_r;
    sb1_nxt.y1    = y1_3_r;
    sb1_nxt.dx    = dx3_r;
    sb1_nxt.dy    = dy3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sb1_r <= '0;
    else if (en) sb1_r <= sb1_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) rad4_r <= {d2_3_r[35:0], 16'b0};
  end

  // distance sqrt
  logic [D8_W-1:0] d8;
  sb1_t            sb1_d;

  cpi_isqrt #(.RW(D8_W)) u_sqrt_d (
    .clk (clk), .en (en), .n (rad4_r), .root (d8)
  );

  cpi_delay #(.W($bits(sb1_t)), .N(D8_W)) u_dly_1 (
    .clk (clk), .rst_n (rst_n), .en (en), .din (sb1_r), .dout (sb1_d)
  );

  // a8 = K * 2^16 / (2 * d8)
  sb2_t          sb2_nxt, sb2_d;
  logic [QW-1:0] qa;

  always_comb begin
    sb2_nxt.v     = sb1_d.v;
    sb2_nxt.far   = sb1_d.far;
    sb2_nxt.cont  = sb1_d.cont;
    sb2_nxt.kneg  = sb1_d.kneg;
    sb2_nxt.r1    = sb1_d.r1;
    sb2_nxt.sq_r1 = sb1_d.sq_r1;
    sb2_nxt.x1    = sb1_d.x1;
    sb2_nxt.y1    = sb1_d.y1;
    sb2_nxt.dx    = sb1_d.dx;
    sb2_nxt.dy    = sb1_d.dy;
    sb2_nxt.d8    = d8;
  end

  cpi_div #(.NW(KMAG_W + 16), .DW(D8_W + 1), .QW(QW)) u_div_a (
    .clk (clk), .en (en), .n ({sb1_d.kmag, 16'b0}), .d ({d8, 1'b0}), .q (qa)
  );

  cpi_delay #(.W($bits(sb2_t)), .N(QW)) u_dly_2 (
    .clk (clk), .rst_n (rst_n), .en (en), .din (sb2_nxt), .dout (sb2_d)
  );

  // stage 5..7: h2 = rs^2 - a8^2, clamped
  sb2_t          sb5_r, sb6_r;
  logic [QW-1:0] amag5_r, amag6_r;
  logic [55:0]   asq6_r;
  logic          age6_r;
  logic [55:0]   h2w;
  logic [49:0]   h2_7_r;
  sb3_t          sb3_r, sb3_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb5_r <= '0;
      sb6_r <= '0;
      sb3_r <= '0;
    end else if (en) begin
      sb5_r         <= sb2_d;
      sb6_r         <= sb5_r;
      sb3_r.v       <= sb6_r.v;
      sb3_r.far     <= sb6_r.far;
      sb3_r.cont    <= sb6_r.cont;
      sb3_r.aneg    <= sb6_r.kneg;
      sb3_r.amag    <= amag6_r;
      sb3_r.d8      <= sb6_r.d8;
      sb3_r.x1      <= sb6_r.x1;
      sb3_r.y1      <= sb6_r.y1;
      sb3_r.dx      <= sb6_r.dx;
      sb3_r.dy      <= sb6_r.dy;
    end
  end

  assign h2w = {6'b0, sb6_r.sq_r1, 16'b0} - asq6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      amag5_r <= qa;
      amag6_r <= amag5_r;
      asq6_r  <= amag5_r * amag5_r;
      age6_r  <= amag5_r >= {3'b0, sb5_r.r1, 8'b0};
      h2_7_r  <= age6_r ? '0 : h2w[49:0];
    end
  end

  // half chord sqrt
  logic [H8_W-1:0] h8;

  cpi_isqrt #(.RW(H8_W)) u_sqrt_h (
    .clk (clk), .en (en), .n (h2_7_r), .root (h8)
  );

  cpi_delay #(.W($bits(sb3_t)), .N(H8_W)) u_dly_3 (
    .clk (clk), .rst_n (rst_n), .en (en), .din (sb3_r), .dout (sb3_d)
  );

  // stage 8: offset numerators
  logic [DLT_W-1:0]  dxm, dym;
  logic [PROD_W-1:0] pmx8_r, pmy8_r, phx8_r, phy8_r;
  logic [D8_W-1:0]   d8_8_r;
  sb4_t              sb8_r, sb8_d;

  assign dxm = sb3_d.dx[DLT_W-1] ? -sb3_d.dx : sb3_d.dx;
  assign dym = sb3_d.dy[DLT_W-1] ? -sb3_d.dy : sb3_d.dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb8_r <= '0;
    end else if (en) begin
      sb8_r.v    <= sb3_d.v;
      sb8_r.far  <= sb3_d.far;
      sb8_r.cont <= sb3_d.cont;
      sb8_r.smx  <= sb3_d.aneg ^ sb3_d.dx[DLT_W-1];
      sb8_r.smy  <= sb3_d.aneg ^ sb3_d.dy[DLT_W-1];
      sb8_r.shx  <= sb3_d.dy[DLT_W-1];
      sb8_r.shy  <= sb3_d.dx[DLT_W-1];
      sb8_r.x1   <= sb3_d.x1;
      sb8_r.y1   <= sb3_d.y1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pmx8_r <= sb3_d.amag * dxm;
      pmy8_r <= sb3_d.amag * dym;
      phx8_r <= h8 * dym;
      phy8_r <= h8 * dxm;
      d8_8_r <= sb3_d.d8;
    end
  end

  logic [QW-1:0] qmx, qmy, qhx, qhy;

  cpi_div #(.NW(PROD_W + GUARD), .DW(D8_W), .QW(QW)) u_div_mx (
    .clk (clk), .en (en), .n ({pmx8_r, 8'b0}), .d (d8_8_r), .q (qmx)
  );
  cpi_div #(.NW(PROD_W + GUARD), .DW(D8_W), .QW(QW)) u_div_my (
    .clk (clk), .en (en), .n ({pmy8_r, 8'b0}), .d (d8_8_r), .q (qmy)
  );
  cpi_div #(.NW(PROD_W + GUARD), .DW(D8_W), .QW(QW)) u_div_hx (
    .clk (clk), .en (en), .n ({phx8_r, 8'b0}), .d (d8_8_r), .q (qhx)
  );
  cpi_div #(.NW(PROD_W + GUARD), .DW(D8_W), .QW(QW)) u_div_hy (
    .clk (clk), .en (en), .n ({phy8_r, 8'b0}), .d (d8_8_r), .q (qhy)
  );

  cpi_delay #(.W($bits(sb4_t)), .N(QW)) u_dly_4 (
    .clk (clk), .rst_n (rst_n), .en (en), .din (sb8_r), .dout (sb8_d)
  );

  // stage 9: signed offsets
  logic             v9_r, far9_r, cont9_r;
  logic [CW-1:0]    x1_9_r, y1_9_r;
  logic [OFS_W-1:0] mx9_r, my9_r, hx9_r, hy9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= sb8_d.v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far9_r  <= sb8_d.far;
      cont9_r <= sb8_d.cont;
      x1_9_r  <= sb8_d.x1;
      y1_9_r  <= sb8_d.y1;
      mx9_r   <= sb8_d.smx ? -{1'b0, qmx} : {1'b0, qmx};
      my9_r   <= sb8_d.smy ? -{1'b0, qmy} : {1'b0, qmy};
      hx9_r   <= sb8_d.shx ? -{1'b0, qhx} : {1'b0, qhx};
      hy9_r   <= sb8_d.shy ? -{1'b0, qhy} : {1'b0, qhy};
    end
  end

  // stage 10: crossing points
  logic             v10_r, far10_r, cont10_r;
  logic [POS_W-1:0] x1e, y1e, mxe, mye, hxe, hye;
  logic [POS_W-1:0] ax10_r, ay10_r, bx10_r, by10_r;

  localparam int OX = POS_W - OFS_W;
  localparam int CX = POS_W - CW - GUARD;

  assign x1e = {{CX{x1_9_r[CW-1]}}, x1_9_r, {GUARD{1'b0}}};
  assign y1e = {{CX{y1_9_r[CW-1]}}, y1_9_r, {GUARD{1'b0}}};
  assign mxe = {{OX{mx9_r[OFS_W-1]}}, mx9_r};
  assign mye = {{OX{my9_r[OFS_W-1]}}, my9_r};
  assign hxe = {{OX{hx9_r[OFS_W-1]}}, hx9_r};
  assign hye = {{OX{hy9_r[OFS_W-1]}}, hy9_r};

  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else if (en) v10_r <= v9_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far10_r  <= far9_r;
      cont10_r <= cont9_r;
      ax10_r   <= x1e + mxe + hxe;
      ay10_r   <= y1e + mye - hye;
      bx10_r   <= x1e + mxe - hxe;
      by10_r   <= y1e + mye + hye;
    end
  end

  // stage 11: frame check and result
  logic [POS_W-1:0] lim_w, lim_h;
  logic [POS_W-1:0] pos [4];
  logic [POS_W-1:0] pw  [4];
  logic [3:0]       onf;
  res_t             res_nxt, res11_r;
  logic             v11_r;

  always_comb begin
    lim_w = ({{(POS_W - FRM_W){1'b0}}, fw_r} > POS_W'(MAX_FRAME)) ?
            POS_W'(MAX_FRAME) : {{(POS_W - FRM_W){1'b0}}, fw_r};
    lim_h = ({{(POS_W - FRM_W){1'b0}}, fh_r} > POS_W'(MAX_FRAME)) ?
            POS_W'(MAX_FRAME) : {{(POS_W - FRM_W){1'b0}}, fh_r};
    pos[0] = ax10_r;
    pos[1] = ay10_r;
    pos[2] = bx10_r;
    pos[3] = by10_r;
    for (int i = 0; i < 4; i++) begin
      pw[i]  = pos[i] >> SH;
      onf[i] = !pos[i][POS_W-1] && (pw[i] < ((i % 2 == 0) ? lim_w : lim_h));
    end
    res_nxt = '0;
    if (far10_r) begin
      res_nxt.status = ST_APART;
    end else if (cont10_r) begin
      res_nxt.status = ST_INSIDE;
    end else if (&onf) begin
      res_nxt.status = ST_VALID;
      res_nxt.pax    = pw[0][PIX_W-1:0];
      res_nxt.pay    = pw[1][PIX_W-1:0];
      res_nxt.pbx    = pw[2][PIX_W-1:0];
      res_nxt.pby    = pw[3][PIX_W-1:0];
    end else begin
      res_nxt.status = ST_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v11_r <= 1'b0;
    else if (en) v11_r <= v10_r;
  end

  always_ff @(posedge clk) begin
    if (en) res11_r <= res_nxt;
  end

  cpi_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .tail_v  (v11_r),
    .tail_d  (res11_r),
    .pipe_en (en),
    .out_ch  (out_ch)
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |=> $stable(v0_r) && $stable(v11_r) && $stable(res11_r))
    else $error("pipeline moved while stalled");
  a_zero_points: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_VALID |->
      out_ch.point_a_x == '0 && out_ch.point_a_y == '0 &&
      out_ch.point_b_x == '0 && out_ch.point_b_y == '0)
    else $error("points set without valid status");
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.ready && cfg_ch.index == CFG_FRAME_W |=>
      fw_r == $past(cfg_ch.data))
    else $error("frame width write lost");

endmodule
